/* hw/rtl/multiclass_margin_perceptron_core_assert.svh */
// Assertion macros shared by the perceptron core modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MULTICLASS_MARGIN_PERCEPTRON_CORE_ASSERT_SVH
`define MULTICLASS_MARGIN_PERCEPTRON_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mmpc_pkg.sv */
// ----------------------------------------------------------------------------
// mmpc_pkg
// Types, constants and helper functions of the multiclass margin perceptron.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmpc_pkg;

    localparam int FEATURE_DIM  = 1024;
    localparam int IDX_W        = $clog2(FEATURE_DIM);
    localparam int MAX_CLASSES  = 16;
    localparam int CLS_W        = $clog2(MAX_CLASSES);
    localparam int NCLS_W       = CLS_W + 1;
    localparam int MAX_NONZERO  = 64;
    localparam int BUF_AW       = $clog2(MAX_NONZERO);
    localparam int CNT_W        = BUF_AW + 1;
    localparam int WADDR_W      = CLS_W + IDX_W;
    localparam int WDEPTH       = MAX_CLASSES * FEATURE_DIM;
    localparam int VAL_W        = 16;
    localparam int W_W          = 32;
    localparam int RATE_W       = 31;
    localparam int PROD_W       = W_W + VAL_W;
    localparam int ACC_W        = PROD_W + BUF_AW;
    localparam int SAT_IN_W     = 44;
    localparam int FRAC_SHIFT   = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [NCLS_W-1:0] NUM_CLASSES_RESET = NCLS_W'(2);
    localparam logic [RATE_W-1:0] MARGIN_RESET      = RATE_W'(65536);
    localparam logic [RATE_W-1:0] LRATE_RESET       = RATE_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CLASSES = 2'd0,
        CFG_MARGIN      = 2'd1,
        CFG_LRATE       = 2'd2
    } t_cfg_idx;

    localparam logic FUNC_TRAIN   = 1'b0;
    localparam logic FUNC_PREDICT = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        feature_index;
        logic signed [VAL_W-1:0] feature_value;
        logic [CLS_W-1:0]        target_class;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic [CLS_W-1:0] chosen_class;
        logic             correct;
        logic             updated;
        logic             dropped;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0]        feature_index;
        logic signed [VAL_W-1:0] feature_value;
    } t_feat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_S_BUF,
        ST_S_WGT,
        ST_S_MUL,
        ST_S_ACC,
        ST_S_FIN,
        ST_S_CMP,
        ST_DECIDE,
        ST_U_BUF,
        ST_U_WGT,
        ST_U_MUL,
        ST_U_WR,
        ST_U_BIAS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_write;
        logic push;
        logic feat_rst;
        logic feat_inc;
        logic cls_rst;
        logic cls_inc;
        logic upd_mode;
        logic mul_load;
        logic acc_clr;
        logic acc_add;
        logic fin;
        logic cmp;
        logic decide;
        logic wr_upd;
        logic bias_upd;
        logic pass2_set;
        logic result;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_last;
        logic last_feat;
        logic last_cls;
        logic upd_now;
        logic do_upd;
        logic pass2;
    } t_dp_status;

    // Saturates a wide signed value to 32 bits.
    function automatic logic signed [W_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] x);
        logic signed [W_W-1:0] r;
        if ((&x[SAT_IN_W-1:W_W-1]) || !(|x[SAT_IN_W-1:W_W-1])) begin
            r = x[W_W-1:0];
        end else if (x[SAT_IN_W-1]) begin
            r = {1'b1, {(W_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mmpc_ctrl.sv */
// ----------------------------------------------------------------------------
// mmpc_ctrl
// Sequencer: clearing pass, scoring walk, decision and two-row update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multiclass_margin_perceptron_core_assert.svh"

module mmpc_ctrl
    import mmpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_last,
    input  wire t_dp_status i_status,
    output t_ctl_cmd        o_cmd,
    output logic            o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_status.clear_last) n_state = ST_IDLE;
            ST_IDLE:   if (i_accept && i_last) n_state = ST_S_BUF;
            ST_S_BUF:  n_state = ST_S_WGT;
            ST_S_WGT:  n_state = ST_S_MUL;
            ST_S_MUL:  n_state = ST_S_ACC;
            ST_S_ACC:  n_state = i_status.last_feat ? ST_S_FIN : ST_S_BUF;
            ST_S_FIN:  n_state = ST_S_CMP;
            ST_S_CMP:  n_state = i_status.last_cls ? ST_DECIDE : ST_S_BUF;
            ST_DECIDE: n_state = i_status.upd_now ? ST_U_BUF : ST_DONE;
            ST_U_BUF:  n_state = ST_U_WGT;
            ST_U_WGT:  n_state = ST_U_MUL;
            ST_U_MUL:  n_state = ST_U_WR;
            ST_U_WR:   n_state = i_status.last_feat ? ST_U_BIAS : ST_U_BUF;
            ST_U_BIAS: n_state = i_status.pass2 ? ST_DONE : ST_U_BUF;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.push     = i_accept;
                o_cmd.feat_rst = 1'b1;
                o_cmd.cls_rst  = 1'b1;
                o_cmd.acc_clr  = 1'b1;
            end
            ST_S_MUL: begin
                o_cmd.mul_load = 1'b1;
            end
            ST_S_ACC: begin
                o_cmd.acc_add  = 1'b1;
                o_cmd.feat_inc = !i_status.last_feat;
            end
            ST_S_FIN: begin
                o_cmd.fin = 1'b1;
            end
            ST_S_CMP: begin
                o_cmd.cmp      = 1'b1;
                o_cmd.cls_inc  = !i_status.last_cls;
                o_cmd.feat_rst = 1'b1;
                o_cmd.acc_clr  = 1'b1;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ST_U_BUF: begin
                o_cmd.upd_mode = 1'b1;
            end
            ST_U_WGT: begin
                o_cmd.upd_mode = 1'b1;
            end
            ST_U_MUL: begin
                o_cmd.upd_mode = 1'b1;
                o_cmd.mul_load = 1'b1;
            end
            ST_U_WR: begin
                o_cmd.upd_mode = 1'b1;
                o_cmd.wr_upd   = 1'b1;
                o_cmd.feat_inc = !i_status.last_feat;
            end
            ST_U_BIAS: begin
                o_cmd.upd_mode  = 1'b1;
                o_cmd.bias_upd  = 1'b1;
                o_cmd.pass2_set = 1'b1;
                o_cmd.feat_rst  = 1'b1;
            end
            ST_DONE: begin
                o_cmd.result = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `MMPC_ASSERT_NEXT(a_done_to_idle, r_state == ST_DONE, r_state == ST_IDLE, "done must return to idle")
    `MMPC_ASSERT_SAME(a_upd_decided, r_state == ST_U_BUF, i_status.do_upd, "update pass without decision")
    `MMPC_ASSERT_NEXT(a_wr_after_mul, r_state == ST_U_MUL, o_cmd.wr_upd, "write-back must follow multiply")

endmodule

`default_nettype wire

/* hw/rtl/mmpc_datapath.sv */
// ----------------------------------------------------------------------------
// mmpc_datapath
// Sample buffer, weight memory, biases, multiplier, accumulator and decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multiclass_margin_perceptron_core_assert.svh"

module mmpc_datapath
    import mmpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl_cmd              i_cmd,
    input  wire t_in_item              i_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_dp_status                 o_status,
    output t_out_item                  o_result,
    output logic                       o_result_valid
);

    // Configuration.
    logic [NCLS_W-1:0] r_num_cls;
    logic [RATE_W-1:0] r_margin;
    logic [RATE_W-1:0] r_lrate;
    logic [NCLS_W-1:0] n_eff;

    // Sample buffer.
    t_feat             r_buf_mem [MAX_NONZERO];
    t_feat             r_buf_q;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic              r_func;
    logic [CLS_W-1:0]  r_target;
    logic [BUF_AW-1:0] r_feat;
    logic [CLS_W-1:0]  r_cls;

    // Weight memory.
    logic signed [W_W-1:0] r_wmem [WDEPTH];
    logic signed [W_W-1:0] r_wq;
    logic [WADDR_W-1:0]    r_clr_addr;
    logic [WADDR_W-1:0]    w_raddr;
    logic [WADDR_W-1:0]    w_waddr;
    logic signed [W_W-1:0] w_wdata;
    logic                  w_we;
    logic [CLS_W-1:0]      w_row;

    // Arithmetic.
    logic signed [W_W-1:0]      mul_a;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [W_W-1:0]      r_score;
    logic signed [SAT_IN_W-1:0] fin_sum;
    logic signed [PROD_W-1:0]   upd_term;
    logic signed [PROD_W-1:0]   upd_shift;
    logic signed [SAT_IN_W-1:0] upd_sum;
    logic signed [SAT_IN_W-1:0] lrate_ext;
    logic signed [SAT_IN_W-1:0] bias_sum;

    // Selection and decision.
    logic signed [W_W-1:0] r_bias [MAX_CLASSES];
    logic signed [W_W-1:0] r_best_score;
    logic [CLS_W-1:0]      r_best_cls;
    logic                  r_found;
    logic signed [W_W-1:0] r_tgt_score;
    logic                  r_do_upd;
    logic                  r_pass2;
    logic signed [W_W:0]   diff;
    logic                  tgt_in;
    logic                  skip;
    t_out_item             r_result;
    logic                  r_strobe;

    always_comb begin
        if (r_num_cls == '0) begin
            n_eff = NCLS_W'(1);
        end else if (r_num_cls > NCLS_W'(MAX_CLASSES)) begin
            n_eff = NCLS_W'(MAX_CLASSES);
        end else begin
            n_eff = r_num_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cls <= NUM_CLASSES_RESET;
            r_margin  <= MARGIN_RESET;
            r_lrate   <= LRATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_CLASSES: r_num_cls <= i_cfg_data[NCLS_W-1:0];
                CFG_MARGIN:      r_margin  <= i_cfg_data[RATE_W-1:0];
                CFG_LRATE:       r_lrate   <= i_cfg_data[RATE_W-1:0];
                default:         r_num_cls <= r_num_cls;
            endcase
        end
    end

    // Sample buffer write on push, registered read at the feature pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !r_count[CNT_W-1]) begin
            r_buf_mem[r_count[BUF_AW-1:0]] <= '{feature_index: i_item.feature_index,
                                                feature_value: i_item.feature_value};
        end
        r_buf_q <= r_buf_mem[r_feat];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.push) begin
            if (r_count[CNT_W-1]) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
        end else if (i_cmd.result) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && i_item.last) begin
            r_func   <= i_item.func;
            r_target <= i_item.target_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat <= '0;
            r_cls  <= '0;
        end else begin
            if (i_cmd.feat_rst) begin
                r_feat <= '0;
            end else if (i_cmd.feat_inc) begin
                r_feat <= r_feat + BUF_AW'(1);
            end
            if (i_cmd.cls_rst) begin
                r_cls <= '0;
            end else if (i_cmd.cls_inc) begin
                r_cls <= r_cls + CLS_W'(1);
            end
        end
    end

    // Weight memory: one write port, one registered read port.
    assign w_row   = r_pass2 ? r_best_cls : r_target;
    assign w_raddr = {(i_cmd.upd_mode ? w_row : r_cls), r_buf_q.feature_index};
    assign w_we    = i_cmd.clr_write || i_cmd.wr_upd;
    assign w_waddr = i_cmd.clr_write ? r_clr_addr : w_raddr;

    // The update term is rounded toward minus infinity by the arithmetic shift.
    assign upd_term  = r_pass2 ? -r_prod : r_prod;
    assign upd_shift = upd_term >>> FRAC_SHIFT;
    assign upd_sum   = SAT_IN_W'(upd_shift) + SAT_IN_W'(r_wq);
    assign w_wdata   = i_cmd.clr_write ? '0 : sat32(upd_sum);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= w_wdata;
        end
        r_wq <= r_wmem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_write) begin
            r_clr_addr <= r_clr_addr + WADDR_W'(1);
        end
    end

    // Shared multiplier: weight times value while scoring, rate times value on update.
    assign mul_a = i_cmd.upd_mode ? $signed({1'b0, r_lrate}) : r_wq;
    assign mul_p = mul_a * r_buf_q.feature_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_prod <= mul_p;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign fin_sum = SAT_IN_W'(r_acc >>> FRAC_SHIFT) + SAT_IN_W'(r_bias[r_cls]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_score <= sat32(fin_sum);
        end
    end

    // Running best; in train mode the target class is left out of the search.
    assign skip = (r_func == FUNC_TRAIN) && (r_cls == r_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.push) begin
            r_found <= 1'b0;
        end else if (i_cmd.cmp && !skip) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            if (r_cls == r_target) begin
                r_tgt_score <= r_score;
            end
            if (!skip && (!r_found || (r_score > r_best_score))) begin
                r_best_score <= r_score;
                r_best_cls   <= r_cls;
            end
        end
    end

    assign tgt_in = ({1'b0, r_target} < n_eff);
    assign diff   = (W_W+1)'(r_tgt_score) - (W_W+1)'(r_best_score);

    assign o_status.upd_now = (r_func == FUNC_TRAIN) && tgt_in && r_found &&
                              (diff < $signed({2'b00, r_margin}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_do_upd <= 1'b0;
            r_pass2  <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                r_do_upd <= o_status.upd_now;
                r_pass2  <= 1'b0;
            end else if (i_cmd.pass2_set) begin
                r_pass2 <= 1'b1;
            end
        end
    end

    // Biases: add the rate to the target row, subtract it from the rival row.
    assign lrate_ext = SAT_IN_W'($signed({1'b0, r_lrate}));
    assign bias_sum  = r_pass2 ? (SAT_IN_W'(r_bias[w_row]) - lrate_ext)
                               : (SAT_IN_W'(r_bias[w_row]) + lrate_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CLASSES; k++) begin
                r_bias[k] <= '0;
            end
        end else if (i_cmd.bias_upd) begin
            r_bias[w_row] <= sat32(bias_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            if (r_func == FUNC_PREDICT) begin
                r_result.chosen_class <= r_best_cls;
            end else if (tgt_in && r_found) begin
                r_result.chosen_class <= r_best_cls;
            end else begin
                r_result.chosen_class <= r_target;
            end
            r_result.correct <= (r_func == FUNC_PREDICT) && (r_best_cls == r_target);
            r_result.updated <= r_do_upd;
            r_result.dropped <= r_ovf;
        end
    end

    assign o_status.clear_last = &r_clr_addr;
    assign o_status.last_feat  = ({1'b0, r_feat} == (r_count - CNT_W'(1)));
    assign o_status.last_cls   = ({1'b0, r_cls} == (n_eff - NCLS_W'(1)));
    assign o_status.do_upd     = r_do_upd;
    assign o_status.pass2      = r_pass2;
    assign o_result            = r_result;
    assign o_result_valid      = r_strobe;

    `MMPC_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_NONZERO), "buffer count overrun")
    `MMPC_ASSERT_NEXT(a_strobe_single, r_strobe, !r_strobe, "result strobe longer than a cycle")
    `MMPC_ASSERT_SAME(a_strobe_cleared, r_strobe, (r_count == '0) && !r_ovf, "buffer not cleared")

endmodule

`default_nettype wire

/* hw/rtl/multiclass_margin_perceptron_core.sv */
// ----------------------------------------------------------------------------
// multiclass_margin_perceptron_core
// Multiclass perceptron with margin over sparse Q4.12 samples, Q16.16 weights.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | word
//  item      | in        | start, busy (taken: start&!busy) | i_item (t_in_item)
//  result    | out       | o_result_valid, one cycle    | o_result (t_out_item)
//  config    | in        | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A non-last word is buffered; a last one starts scoring: per class, each
// buffered feature is weighted and summed, the bias added and the score
// compared; a decision follows, then on update a target-row and a rival-row
// pass rewrite each weight and the bias, then a result step, on one multiplier
// and one weight read port. A clearing pass after reset zeroes all 16384
// weights, busy high. The strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiclass_margin_perceptron_core
    import mmpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_in_item              i_item,
    output t_out_item                  o_result,
    output logic                       o_result_valid,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd   cmd;
    t_dp_status status;
    logic       accept;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    mmpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_last   (i_item.last),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    mmpc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

`default_nettype wire
